@@ design/tq_pkg.sv @@
// ============================================================================
// tq_pkg: shared types and codes of the team queue
// Request and response beats, command and status codes, internal op codes,
// back-end states and the team reduction step count.
// ============================================================================
package tq_pkg;

  localparam int CMD_W        = 2;
  localparam int ELEM_FIELD_W = 20;
  localparam int TEAM_FIELD_W = 10;
  localparam int STATUS_W     = 3;
  localparam int TEAM_FIELD_MAX = 1023;
  localparam int RED_W        = 24;
  localparam int STEP_W       = 4;

  localparam logic [CMD_W-1:0] CMD_ENQ = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLR = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_ENQUEUED = 3'd0,
    ST_DEQUEUED = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_CLEARED  = 3'd4
  } tq_status_t;

  typedef enum logic [1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_CLR = 2'd2
  } tq_op_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ENQ,
    BK_DEQ_ORDER,
    BK_DEQ_TEAM,
    BK_DEQ_DONE,
    BK_CLEAR
  } tq_back_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [ELEM_FIELD_W-1:0] elem_value;
    logic [TEAM_FIELD_W-1:0] team;
  } tq_req_t;

  typedef struct packed {
    tq_status_t              status;
    logic [ELEM_FIELD_W-1:0] elem_out;
  } tq_rsp_t;

  // number of conditional-subtract steps that bring any team field below tc
  function automatic int red_steps(input int tc);
    int cnt;
    cnt = 0;
    for (int n = 0; n < 12; n++) begin
      if ((tc << n) <= TEAM_FIELD_MAX) cnt = n + 1;
    end
    return cnt;
  endfunction

endpackage

@@ design/tq_ram.sv @@
// ============================================================================
// tq_ram: generic single-write, single-read RAM
// One write port and one read port with registered, read-first data.
// ============================================================================
module tq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/tq_front.sv @@
// ============================================================================
// tq_front: request intake and classification
// Drops unused commands, trims the element, reduces the team number below
// the team count one conditional subtract per cycle, and pushes the item.
// ============================================================================
module tq_front #(
  parameter int TEAM_COUNT = 1024,
  parameter int ELEM_WIDTH = 20,
  localparam int TW = $clog2(TEAM_COUNT),
  localparam int IW = 2 + TW + ELEM_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  tq_pkg::tq_req_t  req,
  input  logic             block,
  output logic             stall,
  output logic             q_push,
  output logic [IW-1:0]    q_item,
  input  logic             q_ready
);

  localparam int RED_STEPS = tq_pkg::red_steps(TEAM_COUNT);
  localparam int K_INIT    = (RED_STEPS > 0) ? RED_STEPS - 1 : 0;

  logic                              stage_valid, stage_valid_next;
  tq_pkg::tq_op_t                    stage_op, stage_op_next;
  logic [ELEM_WIDTH-1:0]             stage_elem, stage_elem_next;
  logic [tq_pkg::TEAM_FIELD_W-1:0]   stage_r, stage_r_next;
  logic [tq_pkg::STEP_W-1:0]         stage_k, stage_k_next;

  logic [tq_pkg::RED_W-1:0]          step;
  logic [tq_pkg::RED_W-1:0]          r_wide;
  logic                              done;
  logic                              accept;
  logic [ELEM_WIDTH+tq_pkg::ELEM_FIELD_W-1:0] elem_ext;
  logic [TW+tq_pkg::TEAM_FIELD_W-1:0]         team_ext;

  always_comb begin
    step     = tq_pkg::RED_W'(TEAM_COUNT) << stage_k;
    r_wide   = tq_pkg::RED_W'(stage_r);
    done     = r_wide < tq_pkg::RED_W'(TEAM_COUNT);
    q_push   = stage_valid && done && q_ready;
    stall    = block || (stage_valid && !q_push);
    accept   = req_valid && !stall;
    elem_ext = {{ELEM_WIDTH{1'b0}}, req.elem_value};
    team_ext = {{TW{1'b0}}, stage_r};
    q_item   = {stage_op, team_ext[TW-1:0], stage_elem};

    stage_valid_next = stage_valid;
    stage_op_next    = stage_op;
    stage_elem_next  = stage_elem;
    stage_r_next     = stage_r;
    stage_k_next     = stage_k;

    if (q_push) begin
      stage_valid_next = 1'b0;
    end else if (stage_valid && !done) begin
      if (r_wide >= step) begin
        stage_r_next = stage_r - step[tq_pkg::TEAM_FIELD_W-1:0];
      end
      stage_k_next = stage_k - 1'b1;
    end

    if (accept) begin
      stage_valid_next = 1'b1;
      stage_elem_next  = elem_ext[ELEM_WIDTH-1:0];
      stage_k_next     = tq_pkg::STEP_W'(K_INIT);
      unique case (req.cmd)
        tq_pkg::CMD_ENQ: begin
          stage_op_next = tq_pkg::OP_ENQ;
          stage_r_next  = req.team;
        end
        tq_pkg::CMD_DEQ: begin
          stage_op_next = tq_pkg::OP_DEQ;
          stage_r_next  = '0;
        end
        tq_pkg::CMD_CLR: begin
          stage_op_next = tq_pkg::OP_CLR;
          stage_r_next  = '0;
        end
        default: begin
          stage_valid_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= stage_valid_next;
    end
    stage_op   <= stage_op_next;
    stage_elem <= stage_elem_next;
    stage_r    <= stage_r_next;
    stage_k    <= stage_k_next;
  end

endmodule

@@ design/tq_queue.sv @@
// ============================================================================
// tq_queue: two-entry decoupling queue
// Holds classified items between the front and the back end.
// ============================================================================
module tq_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_item,
  output logic             ready,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] head
);

  logic [WIDTH-1:0] slot [2];
  logic             wp, rp;
  logic [1:0]       count;

  assign ready = (count != 2'd2);
  assign valid = (count != 2'd0);
  assign head  = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      slot[wp] <= push_item;
    end
  end

endmodule

@@ design/tq_back.sv @@
// ============================================================================
// tq_back: command execution over the linked-list store
// Runs enqueue, dequeue and clear against the element, link, team record
// and team order memories, and holds the response register.
// ============================================================================
module tq_back #(
  parameter int TEAM_COUNT = 1024,
  parameter int CAPACITY   = 4096,
  parameter int ELEM_WIDTH = 20,
  localparam int TW = $clog2(TEAM_COUNT),
  localparam int IW = 2 + TW + ELEM_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  logic [IW-1:0]    q_item,
  output logic             q_pop,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output tq_pkg::tq_rsp_t  rsp,
  output logic             clearing
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RW = 1 + 2 * AW;
  localparam int EF = tq_pkg::ELEM_FIELD_W;

  tq_pkg::tq_back_state_t state, state_next;
  logic [TW-1:0]          clr_cnt, clr_cnt_next;
  logic [TW-1:0]          rd_ptr, rd_ptr_next;
  logic [TW-1:0]          wr_ptr, wr_ptr_next;
  logic [CW-1:0]          bump, bump_next;
  logic [CW-1:0]          used, used_next;
  logic [AW-1:0]          free_head, free_head_next;
  logic                   free_valid, free_valid_next;
  logic [TW-1:0]          cur_team, cur_team_next;
  logic [ELEM_WIDTH-1:0]  cur_elem, cur_elem_next;
  logic                   rsp_valid_q, rsp_valid_next;
  tq_pkg::tq_status_t     rsp_status, rsp_status_next;
  logic [EF-1:0]          rsp_elem, rsp_elem_next;

  logic                   elem_we, elem_re;
  logic [AW-1:0]          elem_waddr, elem_raddr;
  logic [ELEM_WIDTH-1:0]  elem_wdata, elem_rdata;
  logic                   link_we, link_re;
  logic [AW-1:0]          link_waddr, link_raddr, link_wdata, link_rdata;
  logic                   team_we, team_re;
  logic [TW-1:0]          team_waddr, team_raddr;
  logic [RW-1:0]          team_wdata, team_rdata;
  logic                   order_we, order_re;
  logic [TW-1:0]          order_waddr, order_raddr, order_wdata, order_rdata;

  tq_pkg::tq_op_t         q_op;
  logic [TW-1:0]          q_team;
  logic [ELEM_WIDTH-1:0]  q_elem;
  logic                   out_free;
  logic [AW-1:0]          slot;
  logic [CW-1:0]          spare;
  logic                   rec_busy;
  logic [AW-1:0]          rec_head, rec_tail;
  logic [EF+ELEM_WIDTH-1:0] elem_out_ext;

  tq_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(CAPACITY)) u_elem (
    .clk(clk), .we(elem_we), .waddr(elem_waddr), .wdata(elem_wdata),
    .re(elem_re), .raddr(elem_raddr), .rdata(elem_rdata)
  );

  tq_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .re(link_re), .raddr(link_raddr), .rdata(link_rdata)
  );

  tq_ram #(.WIDTH(RW), .DEPTH(TEAM_COUNT)) u_team (
    .clk(clk), .we(team_we), .waddr(team_waddr), .wdata(team_wdata),
    .re(team_re), .raddr(team_raddr), .rdata(team_rdata)
  );

  tq_ram #(.WIDTH(TW), .DEPTH(TEAM_COUNT)) u_order (
    .clk(clk), .we(order_we), .waddr(order_waddr), .wdata(order_wdata),
    .re(order_re), .raddr(order_raddr), .rdata(order_rdata)
  );

  assign rsp_valid = rsp_valid_q;
  assign rsp      = '{status: rsp_status, elem_out: rsp_elem};
  assign clearing = (state == tq_pkg::BK_CLEAR);

  always_comb begin
    q_op     = tq_pkg::tq_op_t'(q_item[IW-1 -: 2]);
    q_team   = q_item[ELEM_WIDTH +: TW];
    q_elem   = q_item[ELEM_WIDTH-1:0];
    out_free = !rsp_valid_q || !rsp_stall;
    slot     = free_valid ? free_head : bump[AW-1:0];
    spare    = bump - used;
    rec_busy = team_rdata[RW-1];
    rec_head = team_rdata[2*AW-1:AW];
    rec_tail = team_rdata[AW-1:0];
    elem_out_ext = {{EF{1'b0}}, elem_rdata};

    state_next      = state;
    clr_cnt_next    = clr_cnt;
    rd_ptr_next     = rd_ptr;
    wr_ptr_next     = wr_ptr;
    bump_next       = bump;
    used_next       = used;
    free_head_next  = free_head;
    free_valid_next = free_valid;
    cur_team_next   = cur_team;
    cur_elem_next   = cur_elem;
    rsp_valid_next  = rsp_valid_q && rsp_stall;
    rsp_status_next = rsp_status;
    rsp_elem_next   = rsp_elem;
    q_pop           = 1'b0;

    elem_we  = 1'b0; elem_waddr  = '0; elem_wdata  = '0; elem_re  = 1'b0; elem_raddr  = '0;
    link_we  = 1'b0; link_waddr  = '0; link_wdata  = '0; link_re  = 1'b0; link_raddr  = '0;
    team_we  = 1'b0; team_waddr  = '0; team_wdata  = '0; team_re  = 1'b0; team_raddr  = '0;
    order_we = 1'b0; order_waddr = '0; order_wdata = '0; order_re = 1'b0; order_raddr = '0;

    unique case (state)
      tq_pkg::BK_IDLE: begin
        if (q_valid) begin
          unique case (q_op)
            tq_pkg::OP_ENQ: begin
              if (used == CW'(CAPACITY)) begin
                if (out_free) begin
                  q_pop           = 1'b1;
                  rsp_valid_next  = 1'b1;
                  rsp_status_next = tq_pkg::ST_FULL;
                  rsp_elem_next   = '0;
                end
              end else begin
                q_pop         = 1'b1;
                cur_team_next = q_team;
                cur_elem_next = q_elem;
                team_re       = 1'b1;
                team_raddr    = q_team;
                link_re       = 1'b1;
                link_raddr    = free_head;
                state_next    = tq_pkg::BK_ENQ;
              end
            end
            tq_pkg::OP_DEQ: begin
              if (used == '0) begin
                if (out_free) begin
                  q_pop           = 1'b1;
                  rsp_valid_next  = 1'b1;
                  rsp_status_next = tq_pkg::ST_EMPTY;
                  rsp_elem_next   = '0;
                end
              end else begin
                q_pop       = 1'b1;
                order_re    = 1'b1;
                order_raddr = rd_ptr;
                state_next  = tq_pkg::BK_DEQ_ORDER;
              end
            end
            tq_pkg::OP_CLR: begin
              if (out_free) begin
                q_pop           = 1'b1;
                rd_ptr_next     = '0;
                wr_ptr_next     = '0;
                bump_next       = '0;
                used_next       = '0;
                free_head_next  = '0;
                free_valid_next = 1'b0;
                clr_cnt_next    = '0;
                rsp_valid_next  = 1'b1;
                rsp_status_next = tq_pkg::ST_CLEARED;
                rsp_elem_next   = '0;
                state_next      = tq_pkg::BK_CLEAR;
              end
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end

      tq_pkg::BK_ENQ: begin
        if (out_free) begin
          if (free_valid) begin
            if (spare > CW'(1)) begin
              free_head_next = link_rdata;
            end else begin
              free_valid_next = 1'b0;
            end
          end else begin
            bump_next = bump + CW'(1);
          end
          elem_we    = 1'b1;
          elem_waddr = slot;
          elem_wdata = cur_elem;
          team_we    = 1'b1;
          team_waddr = cur_team;
          if (!rec_busy) begin
            team_wdata  = {1'b1, slot, slot};
            order_we    = 1'b1;
            order_waddr = wr_ptr;
            order_wdata = cur_team;
            wr_ptr_next = (wr_ptr == TW'(TEAM_COUNT - 1)) ? '0 : wr_ptr + TW'(1);
          end else begin
            team_wdata = {1'b1, rec_head, slot};
            link_we    = 1'b1;
            link_waddr = rec_tail;
            link_wdata = slot;
          end
          used_next       = used + CW'(1);
          rsp_valid_next  = 1'b1;
          rsp_status_next = tq_pkg::ST_ENQUEUED;
          rsp_elem_next   = '0;
          state_next      = tq_pkg::BK_IDLE;
        end
      end

      tq_pkg::BK_DEQ_ORDER: begin
        cur_team_next = order_rdata;
        team_re       = 1'b1;
        team_raddr    = order_rdata;
        state_next    = tq_pkg::BK_DEQ_TEAM;
      end

      tq_pkg::BK_DEQ_TEAM: begin
        elem_re    = 1'b1;
        elem_raddr = rec_head;
        link_re    = 1'b1;
        link_raddr = rec_head;
        state_next = tq_pkg::BK_DEQ_DONE;
      end

      tq_pkg::BK_DEQ_DONE: begin
        if (out_free) begin
          team_we    = 1'b1;
          team_waddr = cur_team;
          if (rec_head == rec_tail) begin
            team_wdata  = {1'b0, rec_head, rec_tail};
            rd_ptr_next = (rd_ptr == TW'(TEAM_COUNT - 1)) ? '0 : rd_ptr + TW'(1);
          end else begin
            team_wdata = {1'b1, link_rdata, rec_tail};
          end
          if (free_valid) begin
            link_we    = 1'b1;
            link_waddr = rec_head;
            link_wdata = free_head;
          end
          free_head_next  = rec_head;
          free_valid_next = 1'b1;
          used_next       = used - CW'(1);
          rsp_valid_next  = 1'b1;
          rsp_status_next = tq_pkg::ST_DEQUEUED;
          rsp_elem_next   = elem_out_ext[EF-1:0];
          state_next      = tq_pkg::BK_IDLE;
        end
      end

      tq_pkg::BK_CLEAR: begin
        team_we    = 1'b1;
        team_waddr = clr_cnt;
        team_wdata = '0;
        if (clr_cnt == TW'(TEAM_COUNT - 1)) begin
          state_next = tq_pkg::BK_IDLE;
        end else begin
          clr_cnt_next = clr_cnt + TW'(1);
        end
      end

      default: begin
        state_next = tq_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= tq_pkg::BK_CLEAR;
      clr_cnt     <= '0;
      rd_ptr      <= '0;
      wr_ptr      <= '0;
      bump        <= '0;
      used        <= '0;
      free_head   <= '0;
      free_valid  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state       <= state_next;
      clr_cnt     <= clr_cnt_next;
      rd_ptr      <= rd_ptr_next;
      wr_ptr      <= wr_ptr_next;
      bump        <= bump_next;
      used        <= used_next;
      free_head   <= free_head_next;
      free_valid  <= free_valid_next;
      rsp_valid_q <= rsp_valid_next;
    end
    cur_team   <= cur_team_next;
    cur_elem   <= cur_elem_next;
    rsp_status <= rsp_status_next;
    rsp_elem   <= rsp_elem_next;
  end

endmodule

@@ design/grouped_fifo_team_queue.sv @@
// ============================================================================
// grouped_fifo_team_queue: grouped FIFO over shared linked lists
// Enqueue, dequeue and clear commands on a team queue with a free list.
//
//   channel | handshake           | beat
//   --------+---------------------+-----------------------------------------
//   req     | req_valid/req_stall | tq_req_t: cmd, elem_value, team
//   rsp     | rsp_valid/rsp_stall | tq_rsp_t: status, elem_out
//
// The front takes one beat a cycle while req_stall is low; team reduction
// adds conditional subtract steps when TEAM_COUNT is below 1024. The back
// runs enqueue as team record and free link read, then write-back; dequeue
// as order read, team record read, element and link read, then write-back;
// it answers full, empty or clear from idle. Reset and each clear start a
// pass over every team record in memory; req is stalled during it. A stalled
// rsp holds the back at its final step; a 2-entry queue keeps req moving.
// ============================================================================
module grouped_fifo_team_queue #(
  parameter int TEAM_COUNT = 1024,
  parameter int CAPACITY   = 4096,
  parameter int ELEM_WIDTH = 20
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  tq_pkg::tq_req_t req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output tq_pkg::tq_rsp_t rsp
);

  localparam int TW = $clog2(TEAM_COUNT);
  localparam int IW = 2 + TW + ELEM_WIDTH;

  logic          q_push, q_ready, q_pop, q_valid, clearing;
  logic [IW-1:0] q_in, q_head;

  tq_front #(.TEAM_COUNT(TEAM_COUNT), .ELEM_WIDTH(ELEM_WIDTH)) u_front (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req(req),
    .block(clearing), .stall(req_stall),
    .q_push(q_push), .q_item(q_in), .q_ready(q_ready)
  );

  tq_queue #(.WIDTH(IW)) u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_item(q_in), .ready(q_ready),
    .pop(q_pop), .valid(q_valid), .head(q_head)
  );

  tq_back #(
    .TEAM_COUNT(TEAM_COUNT), .CAPACITY(CAPACITY), .ELEM_WIDTH(ELEM_WIDTH)
  ) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_head), .q_pop(q_pop),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .clearing(clearing)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> q_ready)
    else $error("queue pushed while full");

  a_no_pop_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !q_pop)
    else $error("item taken during team record clearing pass");

  a_elem_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != tq_pkg::ST_DEQUEUED) |-> (rsp.elem_out == '0))
    else $error("nonzero element on a non-dequeue response");

endmodule
